[rtl/spq_pkg.sv]
// Package for the sorted priority queue.
// Holds the payload structs, the per-cell control struct and the fixed field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int unsigned KeyBits    = 48;
  localparam int unsigned HandleBits = 16;
  localparam int unsigned CapBits    = 9;

  localparam logic [CapBits-1:0] CapResetVal = 9'd256;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } spq_mode_e;

  typedef struct packed {
    spq_mode_e             mode;
    logic [KeyBits-1:0]    key;
    logic [HandleBits-1:0] handle;
  } spq_in_t;

  typedef struct packed {
    logic                  out_valid;
    logic [KeyBits-1:0]    out_key;
    logic [HandleBits-1:0] out_handle;
    logic                  dropped_full;
    logic                  now_empty;
    logic                  now_full;
  } spq_out_t;

  typedef struct packed {
    logic [KeyBits-1:0]    key;
    logic [HandleBits-1:0] handle;
  } spq_entry_t;

  // Broadcast to every cell of the chain in the cycle an operation takes effect.
  typedef struct packed {
    logic       ins;
    logic       rem;
    spq_entry_t entry;
  } spq_op_t;

endpackage

`default_nettype wire

[rtl/spq_cell.sv]
// One storage cell of the sorted queue chain.
// Holds one entry; inserts shift toward the tail, removes shift toward the head.
// Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell import spq_pkg::*; (
  input  wire logic       clk_i,
  input  wire spq_op_t    op_i,
  input  wire logic       occ_i,
  input  wire logic       prev_shift_i,
  input  wire spq_entry_t prev_entry_i,
  input  wire spq_entry_t next_entry_i,
  output logic            shift_o,
  output spq_entry_t      entry_o
);

  spq_entry_t entry_q, entry_d;
  logic       keep;

  // An occupied cell whose key is not larger than the new key stays put,
  // which keeps equal keys in arrival order.
  assign keep    = occ_i && (entry_q.key <= op_i.entry.key);
  assign shift_o = !keep;

  always_comb begin
    entry_d = entry_q;
    if (op_i.ins) begin
      if (!keep) begin
        entry_d = prev_shift_i ? prev_entry_i : op_i.entry;
      end
    end else if (op_i.rem) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

[rtl/sorted_priority_queue.sv]
// Top level of the sorted priority queue: a chain of DEPTH cells plus count and result logic.
// Instantiates spq_cell; depends on spq_pkg.
//
//   channel   direction  handshake                    payload
//   in        input      in_valid_i / in_stall_o      in_data_i  (spq_in_t)
//   result    output     res_valid_o / res_stall_i    res_data_o (spq_out_t)
//   config    input      cfg_we_i                     cfg_data_i (capacity limit)
//
// Every transaction gives one result, registered in the cycle after it is accepted; a new one
// can follow each cycle unless the input stalls, as all cells compare and shift in parallel.
// The result register is the only buffer: the input stalls while a result waits
// under a stalled output. Reset empties the queue at once (count cleared, no
// clearing pass) and sets the capacity limit to 256.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue import spq_pkg::*; #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire spq_in_t            in_data_i,
  output logic                    res_valid_o,
  input  wire logic               res_stall_i,
  output spq_out_t                res_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CapBits-1:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned WW = (CW > CapBits) ? CW : CapBits;

  logic [CapBits-1:0] cap_q;
  logic [CW-1:0]      count_q, count_d;
  logic               res_valid_q;
  spq_out_t           res_q;

  logic       accept;
  logic       full_now, empty_now, full_nxt;
  spq_op_t    op;
  spq_entry_t head;

  logic       shift   [DEPTH];
  spq_entry_t entries [DEPTH];

  assign in_stall_o = res_valid_q && res_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // The effective capacity saturates at DEPTH, so the count reaching DEPTH is full too.
  assign empty_now = (count_q == '0);
  assign full_now  = (WW'(count_q) >= WW'(cap_q)) || (count_q == CW'(DEPTH));

  assign op.ins   = accept && (in_data_i.mode == MODE_INSERT) && !full_now;
  assign op.rem   = accept && (in_data_i.mode == MODE_REMOVE) && !empty_now;
  assign op.entry = '{key: in_data_i.key, handle: in_data_i.handle};

  always_comb begin
    count_d = count_q;
    if (op.ins) begin
      count_d = count_q + 1'b1;
    end else if (op.rem) begin
      count_d = count_q - 1'b1;
    end
  end

  assign full_nxt = (WW'(count_d) >= WW'(cap_q)) || (count_d == CW'(DEPTH));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic       occ, prev_shift;
    spq_entry_t prev_entry, next_entry;

    assign occ = (CW'(i) < count_q);

    if (i == 0) begin : g_head
      assign prev_shift = 1'b0;
      assign prev_entry = op.entry;
    end else begin : g_body
      assign prev_shift = shift[i-1];
      assign prev_entry = entries[i-1];
    end

    // The tail cell has no successor; after a remove its content lies beyond the count.
    if (i == DEPTH - 1) begin : g_tail
      assign next_entry = entries[i];
    end else begin : g_inner
      assign next_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .op_i         (op),
      .occ_i        (occ),
      .prev_shift_i (prev_shift),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .shift_o      (shift[i]),
      .entry_o      (entries[i])
    );
  end

  assign head = entries[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapResetVal;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      count_q <= count_d;
      if (accept) begin
        res_valid_q <= 1'b1;
      end else if (!res_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q.out_valid    <= op.rem;
      res_q.out_key      <= op.rem ? head.key : '0;
      res_q.out_handle   <= op.rem ? head.handle : '0;
      res_q.dropped_full <= (in_data_i.mode == MODE_INSERT) && full_now;
      res_q.now_empty    <= (count_d == '0);
      res_q.now_full     <= full_nxt;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_data_o  = res_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count exceeds the chain depth");

  a_remove_dec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    op.rem |=> count_q == $past(count_q) - 1'b1)
    else $error("remove did not decrement the count");

  a_drop_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_data_i.mode == MODE_INSERT) && full_now |=> $stable(count_q))
    else $error("dropped insert changed the count");

  a_empty_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_q.now_empty == (count_q == '0)))
    else $error("empty flag disagrees with the count");

  a_remove_no_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.out_valid |-> !res_q.dropped_full)
    else $error("removed entry flagged as dropped");

endmodule

`default_nettype wire
